>>> rtl/multibit_trie_route_lookup_macros.svh
// Assertion macros for the multibit trie route lookup block.
`ifndef MULTIBIT_TRIE_ROUTE_LOOKUP_MACROS_SVH
`define MULTIBIT_TRIE_ROUTE_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds on every clock edge outside reset.
`define MBT_ASSERT(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mbt assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define MBT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbt assertion failed");

`else

`define MBT_ASSERT(name, clk, rst, expr)
`define MBT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/mbt_pkg.sv
// Shared types and constants for the multibit trie route lookup block.
package mbt_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 6;
  localparam int HOP_IO_W  = 16;
  localparam int LVL_W     = 5;
  localparam int MAX_LEN   = 32;
  localparam int LOOKUP_LEVELS = 16;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_WALK,
    PH_EXPAND,
    PH_ROUTE_A,
    PH_ROUTE_B
  } phase_t;

endpackage

>>> rtl/mbt_if.sv
// Request and response channel interfaces of the route lookup block.
interface mbt_req_if import mbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ADDR_W-1:0]   address;
  logic [LEN_W-1:0]    prefix_len;
  logic [HOP_IO_W-1:0] hop_in;

  modport source (output valid, output mode, output address, output prefix_len,
                  output hop_in, input ready);
  modport sink (input valid, input mode, input address, input prefix_len,
                input hop_in, output ready);
endinterface

interface mbt_rsp_if import mbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [HOP_IO_W-1:0] hop_out;
  logic                status;

  modport source (output valid, output found, output hop_out, output status,
                  input ready);
  modport sink (input valid, input found, input hop_out, input status,
                output ready);
endinterface

>>> rtl/mbt_node_ram.sv
// Node pool memory: one row per trie node, with registered synchronous read.
module mbt_node_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 79
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/mbt_walker.sv
// Trie walk sequencer: reads node rows, allocates children, writes routes.
module mbt_walker import mbt_pkg::*; #(
  parameter int MAX_NODES = 16384,
  parameter int HOP_BITS  = 16,
  parameter int NW        = $clog2(MAX_NODES),
  parameter int RW        = 4 * NW + HOP_BITS + LEN_W + 1
) (
  input  logic          clk,
  input  logic          rst,
  mbt_req_if.sink       req,
  mbt_rsp_if.source     rsp,
  output logic          rd_en,
  output logic [NW-1:0] rd_addr,
  input  logic [RW-1:0] rd_data,
  output logic          wr_en,
  output logic [NW-1:0] wr_addr,
  output logic [RW-1:0] wr_data
);

  localparam int HOP_LSB = 4 * NW;
  localparam int LEN_LSB = HOP_LSB + HOP_BITS;

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [NW:0]         nodes_used, nodes_used_next;
  logic [NW-1:0]       cur, cur_next;
  logic [NW-1:0]       sib, sib_next;
  logic [NW-1:0]       fresh, fresh_next;
  logic [LVL_W-1:0]    k, k_next;
  logic [LVL_W-1:0]    levels;
  logic                odd;
  logic                mode;
  logic [ADDR_W-1:0]   addr_sh, addr_sh_next;
  logic [LEN_W-1:0]    len;
  logic [HOP_BITS-1:0] hop;
  logic                res_found, res_found_next;
  logic [HOP_BITS-1:0] res_hop, res_hop_next;
  logic                res_status, res_status_next;

  logic [NW-1:0]       links [4];
  logic [NW-1:0]       links_mod [4];
  logic [HOP_BITS-1:0] row_hop;
  logic [LEN_W-1:0]    row_len;
  logic                row_valid;
  logic [1:0]          dig;
  logic [1:0]          base;
  logic                alloc_req;
  logic [1:0]          alloc_slot;
  logic                route_req;
  logic                expand_chk;
  logic                pool_full;
  logic                accept;
  logic                out_load;

  logic [LEN_W-1:0]    len_sat;
  logic [31:0]         hop_in_ext;
  logic [31:0]         hop_out_ext;

  for (genvar g = 0; g < 4; g++) begin : g_links
    assign links[g] = rd_data[g * NW +: NW];
  end

  assign row_hop   = rd_data[HOP_LSB +: HOP_BITS];
  assign row_len   = rd_data[LEN_LSB +: LEN_W];
  assign row_valid = rd_data[RW-1];

  assign dig       = addr_sh[ADDR_W-1 -: 2];
  assign base      = {addr_sh[ADDR_W-1], 1'b0};
  assign pool_full = (nodes_used >= (NW+1)'(MAX_NODES));

  assign accept   = req.valid && req.ready;
  assign out_load = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  assign req.ready = (state == ST_IDLE);

  assign len_sat     = (req.prefix_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.prefix_len;
  assign hop_in_ext  = 32'(req.hop_in);
  assign hop_out_ext = 32'(res_hop);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      links_mod[i] = (alloc_slot == 2'(i)) ? nodes_used[NW-1:0] : links[i];
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    nodes_used_next = nodes_used;
    cur_next        = cur;
    sib_next        = sib;
    fresh_next      = fresh;
    k_next          = k;
    addr_sh_next    = addr_sh;
    res_found_next  = res_found;
    res_hop_next    = res_hop;
    res_status_next = res_status;
    rd_en           = 1'b0;
    rd_addr         = cur;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = '0;
    alloc_req       = 1'b0;
    alloc_slot      = dig;
    route_req       = 1'b0;
    expand_chk      = 1'b0;

    unique case (state)
      ST_INIT: begin
        // Clear the root row; every other row is cleared when allocated.
        wr_en      = 1'b1;
        wr_addr    = '0;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (mode == MODE_LOOKUP) begin
          if (row_valid) begin
            res_found_next = 1'b1;
            res_hop_next   = row_hop;
          end
          if (k == levels || links[dig] == '0) begin
            state_next = ST_DONE;
          end else begin
            cur_next     = links[dig];
            k_next       = k + 1'b1;
            addr_sh_next = addr_sh << 2;
            state_next   = ST_READ;
          end
        end else begin
          unique case (phase)
            PH_WALK: begin
              if (k != levels) begin
                if (links[dig] != '0) begin
                  cur_next     = links[dig];
                  k_next       = k + 1'b1;
                  addr_sh_next = addr_sh << 2;
                  state_next   = ST_READ;
                end else begin
                  alloc_req  = 1'b1;
                  alloc_slot = dig;
                end
              end else if (!odd) begin
                route_req  = 1'b1;
                state_next = ST_DONE;
              end else begin
                expand_chk = 1'b1;
              end
            end
            PH_EXPAND: begin
              expand_chk = 1'b1;
            end
            PH_ROUTE_A: begin
              route_req  = 1'b1;
              cur_next   = sib;
              phase_next = PH_ROUTE_B;
              state_next = ST_READ;
            end
            PH_ROUTE_B: begin
              route_req  = 1'b1;
              state_next = ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase

          // Odd length: both siblings exist before either route is written.
          if (expand_chk) begin
            phase_next = PH_EXPAND;
            priority if (links[base] == '0) begin
              alloc_req  = 1'b1;
              alloc_slot = base;
            end else if (links[base + 2'd1] == '0) begin
              alloc_req  = 1'b1;
              alloc_slot = base + 2'd1;
            end else begin
              sib_next   = links[base + 2'd1];
              cur_next   = links[base];
              phase_next = PH_ROUTE_A;
              state_next = ST_READ;
            end
          end

          if (alloc_req) begin
            if (pool_full) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_DONE;
            end else begin
              wr_en           = 1'b1;
              wr_data         = {row_valid, row_len, row_hop,
                                 links_mod[3], links_mod[2], links_mod[1], links_mod[0]};
              fresh_next      = nodes_used[NW-1:0];
              nodes_used_next = nodes_used + 1'b1;
              state_next      = ST_CLEAR;
            end
          end

          // Overwrite only an empty route or a strictly shorter prefix.
          if (route_req && (!row_valid || row_len < len)) begin
            wr_en   = 1'b1;
            wr_data = {1'b1, len, hop, links[3], links[2], links[1], links[0]};
          end
        end
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = fresh;
        if (phase == PH_WALK) begin
          cur_next     = fresh;
          k_next       = k + 1'b1;
          addr_sh_next = addr_sh << 2;
        end
        state_next = ST_READ;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      phase      <= PH_WALK;
      nodes_used <= (NW+1)'(1);
      rsp.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= accept ? PH_WALK : phase_next;
      nodes_used <= nodes_used_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode       <= req.mode;
      addr_sh    <= req.address;
      len        <= len_sat;
      hop        <= hop_in_ext[HOP_BITS-1:0];
      levels     <= (req.mode == MODE_INSERT) ? len_sat[LEN_W-1:1] : LVL_W'(LOOKUP_LEVELS);
      odd        <= (req.mode == MODE_INSERT) && len_sat[0];
      cur        <= '0;
      k          <= '0;
      res_found  <= 1'b0;
      res_hop    <= '0;
      res_status <= STATUS_OK;
    end else begin
      addr_sh    <= addr_sh_next;
      cur        <= cur_next;
      k          <= k_next;
      res_found  <= res_found_next;
      res_hop    <= res_hop_next;
      res_status <= res_status_next;
    end
    sib   <= sib_next;
    fresh <= fresh_next;
    if (out_load) begin
      rsp.found   <= res_found;
      rsp.hop_out <= hop_out_ext[HOP_IO_W-1:0];
      rsp.status  <= res_status;
    end
  end

endmodule

>>> rtl/multibit_trie_route_lookup.sv
// Top level of the stride-2 multibit trie route lookup block.
// Each node row takes a read state, then an evaluate state; a lookup visits up to 17 rows, and
// a new request is taken only after its response is loaded and the block is back in idle.
// An insert adds a clear state per allocated node; an odd length adds the two sibling rows
// and one parent reread per allocated sibling.
// After reset the INIT state clears the root row; the pool then holds only the root.
`include "multibit_trie_route_lookup_macros.svh"

module multibit_trie_route_lookup import mbt_pkg::*; #(
  parameter int MAX_NODES = 16384,
  parameter int HOP_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  mbt_req_if.sink   req,
  mbt_rsp_if.source rsp
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int RW = 4 * NW + HOP_BITS + LEN_W + 1;

  logic          rd_en;
  logic [NW-1:0] rd_addr;
  logic [RW-1:0] rd_data;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [RW-1:0] wr_data;

  mbt_node_ram #(
    .DEPTH (MAX_NODES),
    .AW    (NW),
    .DW    (RW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mbt_walker #(
    .MAX_NODES (MAX_NODES),
    .HOP_BITS  (HOP_BITS),
    .NW        (NW),
    .RW        (RW)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  `MBT_ASSERT(a_no_rw_overlap, clk, rst, !(rd_en && wr_en))
  `MBT_ASSERT(a_idle_no_write, clk, rst, !(req.ready && wr_en))
  `MBT_ASSERT_NEXT(a_accept_reads, clk, rst, req.valid && req.ready, rd_en && !req.ready)
  `MBT_ASSERT(a_full_not_found, clk, rst, !(rsp.valid && rsp.status == STATUS_FULL && rsp.found))

endmodule
